// File: rtl/core/vmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmr_pkg
// Shared types and constants of the virtio MMIO register block: register
// offsets, operation codes, configuration indexes and the queue entry layout.
// ----------------------------------------------------------------------------
package vmr_pkg;

  localparam int NUM_QUEUES           = 1;
  localparam int DRIVER_FEATURE_WORDS = 2;

  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  localparam logic [31:0] MAGIC_WORD   = 32'h7472_6976;
  localparam logic [31:0] VERSION_WORD = 32'd2;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Register offsets in the device window.
  localparam logic [11:0] OFF_MAGIC         = 12'h000;
  localparam logic [11:0] OFF_VERSION       = 12'h004;
  localparam logic [11:0] OFF_DEVICE_ID     = 12'h008;
  localparam logic [11:0] OFF_VENDOR_ID     = 12'h00C;
  localparam logic [11:0] OFF_DEV_FEATURES  = 12'h010;
  localparam logic [11:0] OFF_DEV_FEAT_SEL  = 12'h014;
  localparam logic [11:0] OFF_DRV_FEATURES  = 12'h020;
  localparam logic [11:0] OFF_DRV_FEAT_SEL  = 12'h024;
  localparam logic [11:0] OFF_QUEUE_SEL     = 12'h030;
  localparam logic [11:0] OFF_QUEUE_NUM_MAX = 12'h034;
  localparam logic [11:0] OFF_QUEUE_NUM     = 12'h038;
  localparam logic [11:0] OFF_QUEUE_READY   = 12'h044;
  localparam logic [11:0] OFF_QUEUE_NOTIFY  = 12'h050;
  localparam logic [11:0] OFF_INT_STATUS    = 12'h060;
  localparam logic [11:0] OFF_INT_ACK       = 12'h064;
  localparam logic [11:0] OFF_STATUS        = 12'h070;
  localparam logic [11:0] OFF_DESC_LOW      = 12'h080;
  localparam logic [11:0] OFF_DESC_HIGH     = 12'h084;
  localparam logic [11:0] OFF_AVAIL_LOW     = 12'h090;
  localparam logic [11:0] OFF_AVAIL_HIGH    = 12'h094;
  localparam logic [11:0] OFF_USED_LOW      = 12'h0A0;
  localparam logic [11:0] OFF_USED_HIGH     = 12'h0A4;
  localparam logic [11:0] OFF_CAP_LOW       = 12'h100;
  localparam logic [11:0] OFF_CAP_HIGH      = 12'h104;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DEVICE_KIND  = 3'd0;
  localparam logic [2:0] CFG_VENDOR_CODE  = 3'd1;
  localparam logic [2:0] CFG_FEATURES_LO  = 3'd2;
  localparam logic [2:0] CFG_FEATURES_HI  = 3'd3;
  localparam logic [2:0] CFG_QUEUE_LIMIT  = 3'd4;
  localparam logic [2:0] CFG_CAPACITY     = 3'd5;

  typedef struct packed {
    logic [31:0] device_kind;
    logic [31:0] vendor_code;
    logic [31:0] features_low_word;
    logic [31:0] features_high_word;
    logic [15:0] queue_size_limit;
    logic [63:0] disk_capacity;
  } cfg_regs_t;

  typedef struct packed {
    logic [63:0] used_address;
    logic [63:0] avail_address;
    logic [63:0] desc_address;
    logic [31:0] ready_flag;
    logic [31:0] ring_size;
  } queue_entry_t;

  localparam int ENTRY_W = $bits(queue_entry_t);

  typedef struct packed {
    logic        irq_pulse;
    logic [63:0] used_address;
    logic [63:0] available_address;
    logic [63:0] descriptor_address;
    logic [31:0] ring_entries;
    logic [3:0]  notify_queue;
    logic        notify;
    logic [31:0] read_data;
  } result_t;

endpackage

// File: rtl/core/virtio_mmio_register_block_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtio_mmio_register_block_core
// Register file of a virtio MMIO block-device transport. Per-queue ring state
// lives in a synchronous RAM, read when a beat is taken and written back when
// the beat executes; the scalar registers are held in flops.
// The RAM read-modify-write keeps a new beat from being taken until the last
// one has executed. A result waiting on the output does not stop the next
// beat being taken.
// Reset (rst, synchronous) clears all state and the queue valid bits at once;
// a device status write of zero does the same, configuration is kept.
// ----------------------------------------------------------------------------
module virtio_mmio_register_block_core
  import vmr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Input beats
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // offset[11:0], write_data[43:12], zero pad
  input  logic [2:0]   s_tuser,   // operation[1:0], word_access[2]
  // Result beats
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [263:0] m_tdata,   // read_data[31:0], notify_queue[35:32],
                                  // ring_entries[67:36],
                                  // descriptor_address[131:68],
                                  // available_address[195:132],
                                  // used_address[259:196], zero pad
  output logic [1:0]   m_tuser,   // notify[0], irq_pulse[1]
  // Configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  cfg_regs_t cfg;

  logic [1:0]  op;
  logic        word;
  logic [11:0] off;
  logic [31:0] wdata;

  logic [31:0] feature_select, feature_select_next;
  logic [31:0] driver_feature_select, driver_feature_select_next;
  logic [31:0] driver_feature_words [DRIVER_FEATURE_WORDS];
  logic [31:0] queue_select, queue_select_next;
  logic [31:0] interrupt_bits, interrupt_bits_next;
  logic [31:0] device_status, device_status_next;
  logic [NUM_QUEUES-1:0] queue_valid;

  logic              qok;
  logic [QIDX_W-1:0] ridx;
  logic              accept;
  logic              fire;
  logic              dev_reset;
  logic              drv_feat_we;
  logic              mem_we;
  logic [ENTRY_W-1:0] ram_rdata;
  queue_entry_t      entry;
  queue_entry_t      entry_next;
  result_t           res;
  result_t           res_q;
  logic              out_valid;

  vmr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg)
  );

  assign cfg_ready = 1'b1;

  assign qok  = (queue_select < 32'(NUM_QUEUES));
  assign ridx = qok ? queue_select[QIDX_W-1:0] : '0;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fire     = (state == S_EXEC) && (!out_valid || m_tready);

  vmr_queue_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_QUEUES)
  ) u_queue_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ridx),
    .wdata (entry_next),
    .re    (accept),
    .raddr (ridx),
    .rdata (ram_rdata)
  );

  // An entry not written since the last reset reads as zero.
  assign entry = queue_valid[ridx] ? queue_entry_t'(ram_rdata) : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= s_tuser[1:0];
      word  <= s_tuser[2];
      off   <= s_tdata[11:0];
      wdata <= s_tdata[43:12];
    end
  end

  always_comb begin
    feature_select_next        = feature_select;
    driver_feature_select_next = driver_feature_select;
    queue_select_next          = queue_select;
    interrupt_bits_next        = interrupt_bits;
    device_status_next         = device_status;
    entry_next                 = entry;
    drv_feat_we                = 1'b0;
    mem_we                     = 1'b0;
    dev_reset                  = 1'b0;
    res                        = '0;

    if (op == OP_READ && word) begin
      unique case (off)
        OFF_MAGIC:         res.read_data = MAGIC_WORD;
        OFF_VERSION:       res.read_data = VERSION_WORD;
        OFF_DEVICE_ID:     res.read_data = cfg.device_kind;
        OFF_VENDOR_ID:     res.read_data = cfg.vendor_code;
        OFF_DEV_FEATURES: begin
          if (feature_select == 32'd0) begin
            res.read_data = cfg.features_low_word;
          end else if (feature_select == 32'd1) begin
            res.read_data = cfg.features_high_word;
          end
        end
        OFF_QUEUE_NUM_MAX: res.read_data = qok ? 32'(cfg.queue_size_limit) : 32'd0;
        OFF_QUEUE_READY:   res.read_data = qok ? entry.ready_flag : 32'd0;
        OFF_INT_STATUS:    res.read_data = interrupt_bits;
        OFF_CAP_LOW:       res.read_data = cfg.disk_capacity[31:0];
        OFF_CAP_HIGH:      res.read_data = cfg.disk_capacity[63:32];
        default: ;
      endcase
    end else if (op == OP_WRITE && word) begin
      unique case (off)
        OFF_DEV_FEAT_SEL: feature_select_next = wdata;
        OFF_DRV_FEATURES: drv_feat_we = 1'b1;
        OFF_DRV_FEAT_SEL: driver_feature_select_next = wdata;
        OFF_QUEUE_SEL:    queue_select_next = wdata;
        OFF_QUEUE_NUM: begin
          entry_next.ring_size = wdata;
          mem_we = qok;
        end
        OFF_QUEUE_READY: begin
          entry_next.ready_flag = wdata;
          mem_we = qok;
        end
        OFF_QUEUE_NOTIFY: begin
          if (qok) begin
            res.notify             = 1'b1;
            res.notify_queue       = 4'(ridx);
            res.ring_entries       = entry.ring_size;
            res.descriptor_address = entry.desc_address;
            res.available_address  = entry.avail_address;
            res.used_address       = entry.used_address;
          end
        end
        OFF_INT_ACK: interrupt_bits_next = interrupt_bits & ~wdata;
        OFF_STATUS: begin
          if (wdata != 32'd0) begin
            device_status_next = wdata;
          end else begin
            dev_reset = 1'b1;
          end
        end
        OFF_DESC_LOW: begin
          entry_next.desc_address[31:0] = wdata;
          mem_we = qok;
        end
        OFF_DESC_HIGH: begin
          entry_next.desc_address[63:32] = wdata;
          mem_we = qok;
        end
        OFF_AVAIL_LOW: begin
          entry_next.avail_address[31:0] = wdata;
          mem_we = qok;
        end
        OFF_AVAIL_HIGH: begin
          entry_next.avail_address[63:32] = wdata;
          mem_we = qok;
        end
        OFF_USED_LOW: begin
          entry_next.used_address[31:0] = wdata;
          mem_we = qok;
        end
        OFF_USED_HIGH: begin
          entry_next.used_address[63:32] = wdata;
          mem_we = qok;
        end
        default: ;
      endcase
    end else if (op == OP_EVENT) begin
      interrupt_bits_next = interrupt_bits | 32'd1;
      res.irq_pulse       = 1'b1;
    end

    // Nothing is committed until the result has somewhere to go.
    if (!fire) begin
      mem_we      = 1'b0;
      drv_feat_we = 1'b0;
      dev_reset   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_EXEC;
        S_EXEC: if (fire)   state <= S_IDLE;
        default:            state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || dev_reset) begin
      feature_select        <= '0;
      driver_feature_select <= '0;
      queue_select          <= '0;
      interrupt_bits        <= '0;
      device_status         <= '0;
      queue_valid           <= '0;
      for (int i = 0; i < DRIVER_FEATURE_WORDS; i++) begin
        driver_feature_words[i] <= '0;
      end
    end else if (fire) begin
      feature_select        <= feature_select_next;
      driver_feature_select <= driver_feature_select_next;
      queue_select          <= queue_select_next;
      interrupt_bits        <= interrupt_bits_next;
      device_status         <= device_status_next;
      if (mem_we) begin
        queue_valid[ridx] <= 1'b1;
      end
      for (int i = 0; i < DRIVER_FEATURE_WORDS; i++) begin
        if (drv_feat_we && driver_feature_select == 32'(i)) begin
          driver_feature_words[i] <= wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, res_q.used_address, res_q.available_address,
                     res_q.descriptor_address, res_q.ring_entries,
                     res_q.notify_queue, res_q.read_data};
  assign m_tuser  = {res_q.irq_pulse, res_q.notify};

  // A beat is followed by its execute state before the next is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is still executing");

  // A notify result never carries read data.
  a_notify_no_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
    else $error("notify result with non-zero read data");

  // Notify and interrupt pulse come from different operations.
  a_notify_irq_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("notify and irq pulse in the same result");

  // A result is only produced after an execute cycle.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_EXEC))
    else $error("result raised without an executed item");

endmodule

// File: rtl/core/vmr_queue_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmr_queue_ram
// Single-port-write, single-port-read synchronous RAM with a registered read
// port, holding the per-queue ring state.
// ----------------------------------------------------------------------------
module vmr_queue_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 1,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/vmr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmr_cfg
// Configuration registers: identification words, offered features, queue
// size limit and disk capacity, written through the configuration channel.
// ----------------------------------------------------------------------------
module vmr_cfg
  import vmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output cfg_regs_t   regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.device_kind        <= 32'd2;
      regs.vendor_code        <= 32'd0;
      regs.features_low_word  <= 32'd0;
      regs.features_high_word <= 32'd1;
      regs.queue_size_limit   <= 16'd128;
      regs.disk_capacity      <= 64'd2097152;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEVICE_KIND: regs.device_kind        <= cfg_data[31:0];
        CFG_VENDOR_CODE: regs.vendor_code        <= cfg_data[31:0];
        CFG_FEATURES_LO: regs.features_low_word  <= cfg_data[31:0];
        CFG_FEATURES_HI: regs.features_high_word <= cfg_data[31:0];
        CFG_QUEUE_LIMIT: regs.queue_size_limit   <= cfg_data[15:0];
        CFG_CAPACITY:    regs.disk_capacity      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: tb/virtio_mmio_register_block_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtio_mmio_register_block_core_tb
// Self-checking bench for the virtio MMIO register block. A queue of pending
// accesses feeds a clocked driver, and a clocked monitor predicts every taken
// beat with a shadow register file and checks each result beat field by field.
// The run passes through several configuration settings, with random idling
// on both streams and one long stall of the result side.
// ----------------------------------------------------------------------------
module virtio_mmio_register_block_core_tb
  import vmr_pkg::*;
();

  localparam logic [1:0] OP_NONE      = 2'd3;
  localparam int         QUIET_LIMIT  = 3000;
  localparam int         LONG_HOLD    = 300;
  localparam int         RANDOM_BEATS = 256;

  typedef struct packed {
    logic [1:0]  op;
    logic        word;
    logic [11:0] off;
    logic [31:0] data;
  } access_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [263:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  virtio_mmio_register_block_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  access_t     pending_accesses[$];
  result_t     expected_results[$];
  int          beats_queued = 0;
  int          beats_taken = 0;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          long_holds_asked = 0;
  int          long_holds_served = 0;
  bit          calm = 1'b0;
  bit          in_fire = 1'b0;

  // Shadow of the register file.
  cfg_regs_t   cfg_shadow;
  logic [31:0] feat_sel;
  logic [31:0] drv_feat_sel;
  logic [31:0] drv_feat [DRIVER_FEATURE_WORDS];
  logic [31:0] shadow_qsel;
  logic [31:0] ring_size [NUM_QUEUES];
  logic [31:0] ready_flag [NUM_QUEUES];
  logic [63:0] desc_addr [NUM_QUEUES];
  logic [63:0] avail_addr [NUM_QUEUES];
  logic [63:0] used_addr [NUM_QUEUES];
  logic [31:0] irq_bits;
  logic [31:0] dev_status;

  function automatic void clear_shadow_state();
    feat_sel     = '0;
    drv_feat_sel = '0;
    shadow_qsel  = '0;
    irq_bits     = '0;
    dev_status   = '0;
    for (int i = 0; i < DRIVER_FEATURE_WORDS; i++) drv_feat[i] = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      ring_size[i]  = '0;
      ready_flag[i] = '0;
      desc_addr[i]  = '0;
      avail_addr[i] = '0;
      used_addr[i]  = '0;
    end
  endfunction

  task automatic apply_config(input logic [2:0] index, input logic [63:0] value);
    case (index)
      CFG_DEVICE_KIND: cfg_shadow.device_kind        = value[31:0];
      CFG_VENDOR_CODE: cfg_shadow.vendor_code        = value[31:0];
      CFG_FEATURES_LO: cfg_shadow.features_low_word  = value[31:0];
      CFG_FEATURES_HI: cfg_shadow.features_high_word = value[31:0];
      CFG_QUEUE_LIMIT: cfg_shadow.queue_size_limit   = value[15:0];
      CFG_CAPACITY:    cfg_shadow.disk_capacity      = value;
      default: ;
    endcase
  endtask

  function automatic result_t step_register_file(input access_t a);
    result_t     r;
    logic        qok;
    logic [31:0] q;
    r   = '0;
    qok = (shadow_qsel < NUM_QUEUES);
    q   = qok ? shadow_qsel : 32'd0;
    case (a.op)
      OP_READ: if (a.word) begin
        case (a.off)
          OFF_MAGIC:         r.read_data = MAGIC_WORD;
          OFF_VERSION:       r.read_data = VERSION_WORD;
          OFF_DEVICE_ID:     r.read_data = cfg_shadow.device_kind;
          OFF_VENDOR_ID:     r.read_data = cfg_shadow.vendor_code;
          OFF_DEV_FEATURES:
            if (feat_sel == 32'd0) r.read_data = cfg_shadow.features_low_word;
            else if (feat_sel == 32'd1) r.read_data = cfg_shadow.features_high_word;
          OFF_QUEUE_NUM_MAX: if (qok) r.read_data = {16'd0, cfg_shadow.queue_size_limit};
          OFF_QUEUE_READY:   if (qok) r.read_data = ready_flag[q];
          OFF_INT_STATUS:    r.read_data = irq_bits;
          OFF_CAP_LOW:       r.read_data = cfg_shadow.disk_capacity[31:0];
          OFF_CAP_HIGH:      r.read_data = cfg_shadow.disk_capacity[63:32];
          default: ;
        endcase
      end
      OP_WRITE: if (a.word) begin
        case (a.off)
          OFF_DEV_FEAT_SEL: feat_sel = a.data;
          OFF_DRV_FEATURES:
            if (drv_feat_sel < DRIVER_FEATURE_WORDS) drv_feat[drv_feat_sel] = a.data;
          OFF_DRV_FEAT_SEL: drv_feat_sel = a.data;
          OFF_QUEUE_SEL:    shadow_qsel = a.data;
          OFF_QUEUE_NUM:    if (qok) ring_size[q] = a.data;
          OFF_QUEUE_READY:  if (qok) ready_flag[q] = a.data;
          OFF_QUEUE_NOTIFY: if (qok) begin
            r.notify             = 1'b1;
            r.notify_queue       = q[3:0];
            r.ring_entries       = ring_size[q];
            r.descriptor_address = desc_addr[q];
            r.available_address  = avail_addr[q];
            r.used_address       = used_addr[q];
          end
          OFF_INT_ACK:      irq_bits = irq_bits & ~a.data;
          OFF_STATUS:
            if (a.data != 32'd0) dev_status = a.data;
            else clear_shadow_state();
          OFF_DESC_LOW:     if (qok) desc_addr[q][31:0]   = a.data;
          OFF_DESC_HIGH:    if (qok) desc_addr[q][63:32]  = a.data;
          OFF_AVAIL_LOW:    if (qok) avail_addr[q][31:0]  = a.data;
          OFF_AVAIL_HIGH:   if (qok) avail_addr[q][63:32] = a.data;
          OFF_USED_LOW:     if (qok) used_addr[q][31:0]   = a.data;
          OFF_USED_HIGH:    if (qok) used_addr[q][63:32]  = a.data;
          default: ;
        endcase
      end
      OP_EVENT: begin
        irq_bits[0] = 1'b1;
        r.irq_pulse = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endtask

  // Monitor: samples both streams and the configuration channel at the edge.
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    access_t taken;
    in_fire = s_tvalid && s_tready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_config(cfg_index, cfg_data);
      if (m_tvalid && m_tready) begin
        got                    = '0;
        got.read_data          = m_tdata[31:0];
        got.notify_queue       = m_tdata[35:32];
        got.ring_entries       = m_tdata[67:36];
        got.descriptor_address = m_tdata[131:68];
        got.available_address  = m_tdata[195:132];
        got.used_address       = m_tdata[259:196];
        got.notify             = m_tuser[0];
        got.irq_pulse          = m_tuser[1];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          report_field("read_data", 64'(want.read_data), 64'(got.read_data));
          report_field("notify", 64'(want.notify), 64'(got.notify));
          report_field("notify_queue", 64'(want.notify_queue), 64'(got.notify_queue));
          report_field("ring_entries", 64'(want.ring_entries), 64'(got.ring_entries));
          report_field("descriptor_address", want.descriptor_address,
                       got.descriptor_address);
          report_field("available_address", want.available_address,
                       got.available_address);
          report_field("used_address", want.used_address, got.used_address);
          report_field("irq_pulse", 64'(want.irq_pulse), 64'(got.irq_pulse));
        end
      end
      // A result leaving at this edge belongs to an earlier beat, so the
      // new expectation goes in after the comparison.
      if (in_fire) begin
        taken.off  = s_tdata[11:0];
        taken.data = s_tdata[43:12];
        taken.op   = s_tuser[1:0];
        taken.word = s_tuser[2];
        expected_results.push_back(step_register_file(taken));
        beats_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Driver: holds a beat until it is taken, then offers the next one or idles.
  int send_gap = 0;
  always @(negedge clk) begin : driver
    access_t a;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_accesses.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 16);
        s_tvalid <= 1'b0;
      end else begin
        a = pending_accesses.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, a.data, a.off};
        s_tuser  <= {a.word, a.op};
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  int hold_left = 0;
  always @(negedge clk) begin
    if (long_holds_served != long_holds_asked) begin
      long_holds_served++;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic queue_access(input logic [1:0] op, input logic word,
                              input logic [11:0] off, input logic [31:0] data);
    access_t a;
    a.op   = op;
    a.word = word;
    a.off  = off;
    a.data = data;
    pending_accesses.push_back(a);
    beats_queued++;
  endtask

  function automatic logic [11:0] known_offset(input int idx);
    case (idx)
      0:  return OFF_MAGIC;
      1:  return OFF_VERSION;
      2:  return OFF_DEVICE_ID;
      3:  return OFF_VENDOR_ID;
      4:  return OFF_DEV_FEATURES;
      5:  return OFF_DEV_FEAT_SEL;
      6:  return OFF_DRV_FEATURES;
      7:  return OFF_DRV_FEAT_SEL;
      8:  return OFF_QUEUE_SEL;
      9:  return OFF_QUEUE_NUM_MAX;
      10: return OFF_QUEUE_NUM;
      11: return OFF_QUEUE_READY;
      12: return OFF_QUEUE_NOTIFY;
      13: return OFF_INT_STATUS;
      14: return OFF_INT_ACK;
      15: return OFF_STATUS;
      16: return OFF_DESC_LOW;
      17: return OFF_DESC_HIGH;
      18: return OFF_AVAIL_LOW;
      19: return OFF_AVAIL_HIGH;
      20: return OFF_USED_LOW;
      21: return OFF_USED_HIGH;
      22: return OFF_CAP_LOW;
      default: return OFF_CAP_HIGH;
    endcase
  endfunction

  // Mostly decoded offsets with selects kept in range, so that queue state
  // and notifies are reached; the rest is arbitrary offsets and odd selects.
  task automatic queue_random_accesses(input int count);
    access_t a;
    int      pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      a.op = OP_READ;
      else if (pick < 85) a.op = OP_WRITE;
      else if (pick < 95) a.op = OP_EVENT;
      else                a.op = OP_NONE;
      a.word = ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 4) == 0) a.off = 12'($urandom_range(0, 4095));
      else a.off = known_offset($urandom_range(0, 23));
      case ($urandom_range(0, 9))
        0:       a.data = '0;
        1:       a.data = '1;
        default: a.data = $urandom;
      endcase
      if (a.op == OP_WRITE) begin
        case (a.off)
          OFF_QUEUE_SEL:
            if ($urandom_range(0, 4) != 0) a.data = $urandom_range(0, NUM_QUEUES - 1);
          OFF_DEV_FEAT_SEL, OFF_DRV_FEAT_SEL:
            if ($urandom_range(0, 4) != 0) a.data = $urandom_range(0, 3);
          OFF_STATUS:
            if (a.data == 32'd0 && $urandom_range(0, 3) != 0) a.data = 32'h0000_000F;
          default: ;
        endcase
      end
      pending_accesses.push_back(a);
      beats_queued++;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (beats_taken != beats_queued || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_config(input logic [2:0] index, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_config(input logic [31:0] kind, input logic [31:0] vendor,
                                input logic [31:0] feat_lo, input logic [31:0] feat_hi,
                                input logic [15:0] limit, input logic [63:0] capacity);
    write_config(CFG_DEVICE_KIND, {32'd0, kind});
    write_config(CFG_VENDOR_CODE, {32'd0, vendor});
    write_config(CFG_FEATURES_LO, {32'd0, feat_lo});
    write_config(CFG_FEATURES_HI, {32'd0, feat_hi});
    write_config(CFG_QUEUE_LIMIT, {48'd0, limit});
    write_config(CFG_CAPACITY, capacity);
  endtask

  initial begin
    cfg_shadow.device_kind        = 32'd2;
    cfg_shadow.vendor_code        = 32'd0;
    cfg_shadow.features_low_word  = 32'd0;
    cfg_shadow.features_high_word = 32'd1;
    cfg_shadow.queue_size_limit   = 16'd128;
    cfg_shadow.disk_capacity      = 64'd2097152;
    clear_shadow_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed accesses with the reset configuration.
    queue_access(OP_READ, 1'b1, OFF_MAGIC, '0);
    queue_access(OP_READ, 1'b1, OFF_VERSION, '0);
    queue_access(OP_READ, 1'b1, OFF_DEVICE_ID, '0);
    queue_access(OP_READ, 1'b1, OFF_VENDOR_ID, '0);
    queue_access(OP_READ, 1'b1, OFF_DEV_FEATURES, '0);
    queue_access(OP_WRITE, 1'b1, OFF_DEV_FEAT_SEL, 32'd1);
    queue_access(OP_READ, 1'b1, OFF_DEV_FEATURES, '0);
    queue_access(OP_WRITE, 1'b1, OFF_DEV_FEAT_SEL, '1);
    queue_access(OP_READ, 1'b1, OFF_DEV_FEATURES, '0);
    queue_access(OP_WRITE, 1'b1, OFF_DRV_FEAT_SEL, 32'd5);
    queue_access(OP_WRITE, 1'b1, OFF_DRV_FEATURES, '1);
    queue_access(OP_WRITE, 1'b1, OFF_QUEUE_NUM, '1);
    queue_access(OP_WRITE, 1'b1, OFF_DESC_HIGH, '1);
    queue_access(OP_WRITE, 1'b1, OFF_AVAIL_LOW, 32'h8000_0001);
    queue_access(OP_WRITE, 1'b1, OFF_USED_HIGH, 32'hFFFF_0000);
    queue_access(OP_WRITE, 1'b1, OFF_QUEUE_READY, 32'd1);
    queue_access(OP_READ, 1'b1, OFF_QUEUE_READY, '0);
    queue_access(OP_WRITE, 1'b1, OFF_QUEUE_NOTIFY, '0);
    // Queue select out of range: per-queue reads and notify are dead.
    queue_access(OP_WRITE, 1'b1, OFF_QUEUE_SEL, 32'd1);
    queue_access(OP_READ, 1'b1, OFF_QUEUE_NUM_MAX, '0);
    queue_access(OP_WRITE, 1'b1, OFF_QUEUE_NOTIFY, '0);
    queue_access(OP_WRITE, 1'b0, OFF_QUEUE_SEL, '0);
    queue_access(OP_READ, 1'b0, OFF_MAGIC, '0);
    queue_access(OP_EVENT, 1'b0, 12'hFFF, '1);
    queue_access(OP_READ, 1'b1, OFF_INT_STATUS, '0);
    queue_access(OP_WRITE, 1'b1, OFF_INT_ACK, 32'd1);
    queue_access(OP_NONE, 1'b1, 12'hFFF, '1);
    queue_access(OP_WRITE, 1'b1, OFF_STATUS, '0);
    queue_access(OP_READ, 1'b1, OFF_CAP_LOW, '0);
    queue_access(OP_READ, 1'b1, OFF_CAP_HIGH, '0);
    wait_idle();

    program_config('0, '0, '0, '0, '0, '0);
    queue_random_accesses(RANDOM_BEATS);
    wait_idle();

    program_config('1, '1, '1, '1, '1, '1);
    queue_random_accesses(RANDOM_BEATS);
    wait_idle();

    // The result side stalls for a long stretch while beats keep coming.
    program_config($urandom, $urandom, $urandom, $urandom,
                   16'($urandom_range(0, 65535)), {$urandom, $urandom});
    long_holds_asked++;
    queue_random_accesses(RANDOM_BEATS);
    wait_idle();

    program_config($urandom, $urandom, $urandom, $urandom,
                   16'($urandom_range(0, 65535)), {$urandom, $urandom});
    queue_random_accesses(RANDOM_BEATS);
    wait_idle();

    calm = 1'b1;
    program_config(32'd2, 32'd0, $urandom, 32'd1, 16'd128, 64'd2097152);
    queue_random_accesses(RANDOM_BEATS);
    wait_idle();
    repeat (8) @(negedge clk);

    if (expected_results.size() != 0) begin
      fail_count += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/vmr_pkg.sv
rtl/core/vmr_queue_ram.sv
rtl/core/vmr_cfg.sv
rtl/core/virtio_mmio_register_block_core.sv
tb/virtio_mmio_register_block_core_tb.sv
